/* hw/rtl/bsf_pkg.sv */
// bsf_pkg: shared widths, constants, register indexes and word types
// for the bulk surface flux core; no dependencies

package bsf_pkg;

  localparam int W     = 32;
  localparam int F     = 16;
  localparam int RW    = W - 1;
  localparam int SQW   = RW + F;
  localparam int RTW   = (SQW + 1) / 2;
  localparam int NLANE = 3;
  localparam int QD    = 4;
  localparam int QAW   = $clog2(QD);
  localparam int QCW   = $clog2(QD + 1);
  localparam int CIW   = 8;

  localparam logic [1:0] LANE_U = 2'd0;
  localparam logic [1:0] LANE_V = 2'd1;
  localparam logic [1:0] LANE_S = 2'd2;

  localparam logic [CIW-1:0] REG_MOMENTUM_COEF = CIW'(0);
  localparam logic [CIW-1:0] REG_SCALAR_COEF   = CIW'(1);
  localparam logic [CIW-1:0] REG_LEVEL_HEIGHT  = CIW'(2);

  localparam logic [RW-1:0] MC_RESET = RW'(66);
  localparam logic [RW-1:0] SC_RESET = RW'(66);
  localparam logic [RW-1:0] LH_RESET = RW'(1) << F;

  localparam logic [W-1:0]  SMIN      = W'(1) << (W - 1);
  localparam logic [W-1:0]  SMAX      = ~SMIN;
  localparam logic [RW-1:0] RMASK     = '1;
  localparam logic [RW-1:0] MIN_SPEED = RW'(((64'd1 << F) + 64'd5) / 64'd10);

  typedef struct packed {
    logic [W+1:0]               ax;
    logic [W+1:0]               ay;
    logic                       big;
    logic [NLANE-1:0][W:0]      md;
    logic [NLANE-1:0]           dpos;
    logic [NLANE-1:0]           dneg;
    logic [W-1:0]               mb;
    logic                       b_pos;
    logic                       b_zero;
  } cls_t;

  typedef struct packed {
    logic [RW-1:0]  mc;
    logic [RW-1:0]  sc;
    logic [RW-1:0]  lh;
    logic [RTW-1:0] root;
  } cfg_t;

  typedef struct packed {
    logic [RW-1:0] wind_diff;
    logic [W-1:0]  u_flux;
    logic [W-1:0]  v_flux;
    logic [W-1:0]  u_grad;
    logic [W-1:0]  v_grad;
    logic [W-1:0]  s_flux;
    logic [W-1:0]  s_grad;
    logic [RW-1:0] friction_vel;
    logic [W-1:0]  obukhov_len;
  } res_t;

endpackage

/* hw/rtl/bsf_if.sv */
// bsf_if: valid/ready channel interfaces for input words, result words
// and register writes; depends on bsf_pkg

interface bsf_in_if;
  import bsf_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [W-1:0] u_here;
  logic signed [W-1:0] u_east;
  logic signed [W-1:0] v_here;
  logic signed [W-1:0] v_north;
  logic signed [W-1:0] u_surf_here;
  logic signed [W-1:0] u_surf_east;
  logic signed [W-1:0] v_surf_here;
  logic signed [W-1:0] v_surf_north;
  logic signed [W-1:0] scalar_air;
  logic signed [W-1:0] scalar_surf;
  logic signed [W-1:0] buoy_flux;

  modport source (
    output valid, u_here, u_east, v_here, v_north, u_surf_here, u_surf_east,
           v_surf_here, v_surf_north, scalar_air, scalar_surf, buoy_flux,
    input  ready
  );
  modport sink (
    input  valid, u_here, u_east, v_here, v_north, u_surf_here, u_surf_east,
           v_surf_here, v_surf_north, scalar_air, scalar_surf, buoy_flux,
    output ready
  );
endinterface

interface bsf_out_if;
  import bsf_pkg::*;
  logic                valid;
  logic                ready;
  logic [RW-1:0]       wind_diff;
  logic signed [W-1:0] u_flux;
  logic signed [W-1:0] v_flux;
  logic signed [W-1:0] u_grad;
  logic signed [W-1:0] v_grad;
  logic signed [W-1:0] s_flux;
  logic signed [W-1:0] s_grad;
  logic [RW-1:0]       friction_vel;
  logic signed [W-1:0] obukhov_len;

  modport source (
    output valid, wind_diff, u_flux, v_flux, u_grad, v_grad, s_flux, s_grad,
           friction_vel, obukhov_len,
    input  ready
  );
  modport sink (
    input  valid, wind_diff, u_flux, v_flux, u_grad, v_grad, s_flux, s_grad,
           friction_vel, obukhov_len,
    output ready
  );
endinterface

interface bsf_cfg_if;
  import bsf_pkg::*;
  logic           valid;
  logic           ready;
  logic [CIW-1:0] index;
  logic [W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/bulk_surface_flux_core.sv */
// bulk_surface_flux_core: top level, front classifier, queue, back pipeline
// throughput: one word per cycle while the queue is not full;
// the back pipeline stalls as a whole on out_ch
// reset: control and coefficient registers take their reset values and the
// coefficient root unit runs anew, also after each momentum coefficient write
// depends on bsf_pkg, bsf_if, bsf_cfg, bsf_front, bsf_queue, bsf_back

module bulk_surface_flux_core (
  input  logic      clk,
  input  logic      rst_n,
  bsf_in_if.sink    in_ch,
  bsf_out_if.source out_ch,
  bsf_cfg_if.sink   cfg_ch
);
  import bsf_pkg::*;

  cfg_t cfg;
  cls_t fr_word, q_head;
  res_t res;
  logic push, q_full, q_nempty, pop;

  bsf_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bsf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cls    (fr_word)
  );

  bsf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_word (fr_word),
    .full    (q_full),
    .pop     (pop),
    .nempty  (q_nempty),
    .head    (q_head)
  );

  bsf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_nempty),
    .pop        (pop),
    .cfg        (cfg),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.wind_diff    = res.wind_diff;
  assign out_ch.u_flux       = res.u_flux;
  assign out_ch.v_flux       = res.v_flux;
  assign out_ch.u_grad       = res.u_grad;
  assign out_ch.v_grad       = res.v_grad;
  assign out_ch.s_flux       = res.s_flux;
  assign out_ch.s_grad       = res.s_grad;
  assign out_ch.friction_vel = res.friction_vel;
  assign out_ch.obukhov_len  = res.obukhov_len;

endmodule

/* hw/rtl/bsf_cfg.sv */
// bsf_cfg: coefficient and level height registers, plus a bit-serial
// square root of the momentum coefficient; depends on bsf_pkg, bsf_if

module bsf_cfg (
  input  logic          clk,
  input  logic          rst_n,
  bsf_cfg_if.sink       cfg_ch,
  output bsf_pkg::cfg_t cfg
);
  import bsf_pkg::*;

  localparam logic [SQW-1:0] SB_TOP = SQW'(1) << (((SQW - 1) / 2) * 2);

  logic [RW-1:0]  mc_r, sc_r, lh_r;
  logic [SQW-1:0] sx_r, sr_r, sb_r;
  logic [SQW-1:0] st;

  assign cfg_ch.ready = 1'b1;
  assign st = sr_r + sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r <= MC_RESET;
      sc_r <= SC_RESET;
      lh_r <= LH_RESET;
      sx_r <= {MC_RESET, {F{1'b0}}};
      sr_r <= '0;
      sb_r <= SB_TOP;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_MOMENTUM_COEF: begin
          mc_r <= cfg_ch.data[RW-1:0];
          sx_r <= {cfg_ch.data[RW-1:0], {F{1'b0}}};
          sr_r <= '0;
          sb_r <= SB_TOP;
        end
        REG_SCALAR_COEF:  sc_r <= cfg_ch.data[RW-1:0];
        REG_LEVEL_HEIGHT: lh_r <= cfg_ch.data[RW-1:0];
        default: ;
      endcase
    end else if (sb_r != '0) begin
      if (sx_r >= st) begin
        sx_r <= sx_r - st;
        sr_r <= (sr_r >> 1) + sb_r;
      end else begin
        sr_r <= sr_r >> 1;
      end
      sb_r <= sb_r >> 2;
    end
  end

  assign cfg.mc   = mc_r;
  assign cfg.sc   = sc_r;
  assign cfg.lh   = (lh_r == '0) ? RW'(1) : lh_r;
  assign cfg.root = sr_r[RTW-1:0];

endmodule

/* hw/rtl/bsf_front.sv */
// bsf_front: takes input words, forms wind differences, magnitudes and
// sign classes into one registered word; depends on bsf_pkg, bsf_if

module bsf_front (
  input  logic          clk,
  input  logic          rst_n,
  bsf_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output bsf_pkg::cls_t cls
);
  import bsf_pkg::*;

  logic                fr_v_r;
  cls_t                fr_r, cls_nxt;
  logic signed [W+1:0] dx, dy;
  logic signed [W:0]   dl [NLANE];

  assign dx = ((W+2)'(in_ch.u_here) + (W+2)'(in_ch.u_east))
            - ((W+2)'(in_ch.u_surf_here) + (W+2)'(in_ch.u_surf_east));
  assign dy = ((W+2)'(in_ch.v_here) + (W+2)'(in_ch.v_north))
            - ((W+2)'(in_ch.v_surf_here) + (W+2)'(in_ch.v_surf_north));

  assign dl[LANE_U] = (W+1)'(in_ch.u_here) - (W+1)'(in_ch.u_surf_here);
  assign dl[LANE_V] = (W+1)'(in_ch.v_here) - (W+1)'(in_ch.v_surf_here);
  assign dl[LANE_S] = (W+1)'(in_ch.scalar_air) - (W+1)'(in_ch.scalar_surf);

  always_comb begin
    cls_nxt.ax  = dx[W+1] ? (W+2)'(~dx + 1'b1) : (W+2)'(dx);
    cls_nxt.ay  = dy[W+1] ? (W+2)'(~dy + 1'b1) : (W+2)'(dy);
    cls_nxt.big = (cls_nxt.ax[W+1:W] != 2'b00) || (cls_nxt.ay[W+1:W] != 2'b00);
    for (int l = 0; l < NLANE; l++) begin
      cls_nxt.md[l]   = dl[l][W] ? (W+1)'(~dl[l] + 1'b1) : (W+1)'(dl[l]);
      cls_nxt.dpos[l] = !dl[l][W] && (dl[l] != '0);
      cls_nxt.dneg[l] = dl[l][W];
    end
    cls_nxt.mb     = in_ch.buoy_flux[W-1] ? W'(~in_ch.buoy_flux + 1'b1)
                                          : W'(in_ch.buoy_flux);
    cls_nxt.b_pos  = !in_ch.buoy_flux[W-1] && (in_ch.buoy_flux != '0);
    cls_nxt.b_zero = (in_ch.buoy_flux == '0);
  end

  assign in_ch.ready = !fr_v_r || !q_full;
  assign push        = fr_v_r && !q_full;
  assign cls         = fr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      fr_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      fr_r <= cls_nxt;
    end
  end

endmodule

/* hw/rtl/bsf_queue.sv */
// bsf_queue: short queue of classified words between front and back
// depends on bsf_pkg

module bsf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bsf_pkg::cls_t wr_word,
  output logic          full,
  input  logic          pop,
  output logic          nempty,
  output bsf_pkg::cls_t head
);
  import bsf_pkg::*;

  cls_t           mem_r [QD];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r;

  assign full   = (cnt_r == QCW'(QD));
  assign nempty = (cnt_r != '0);
  assign head   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QAW'(QD - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QAW'(QD - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_word;
    end
  end

endmodule

/* hw/rtl/bsf_back.sv */
// bsf_back: stalling pipeline for wind speed root, fluxes, gradient
// dividers, friction velocity and obukhov length divider; depends on bsf_pkg

module bsf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  bsf_pkg::cls_t head,
  input  logic          head_valid,
  output logic          pop,
  input  bsf_pkg::cfg_t cfg,
  output logic          res_valid,
  input  logic          res_ready,
  output bsf_pkg::res_t res
);
  import bsf_pkg::*;

  localparam int SQ_N  = W;
  localparam int S_SPD = SQ_N + 3;
  localparam int S_K   = S_SPD + 2;
  localparam int S_PP  = S_K + 1;
  localparam int S_FLX = S_PP + 1;
  localparam int S_U3  = S_FLX + 1;
  localparam int S_N   = S_U3 + 1;
  localparam int L     = S_N + RW + 1;
  localparam int S_GRD = RW + 2;
  localparam int RADW  = 2 * W;
  localparam int KW    = 2 * RW - F;
  localparam int KL    = KW / 2;
  localparam int KH    = KW - KL;
  localparam int PW    = KW + W + 1;
  localparam int MW    = PW - F;
  localparam int UPW   = RTW + RW;
  localparam int USW   = UPW - F;
  localparam int U3W   = 3 * RW;
  localparam int NW    = U3W + 3;
  localparam int DW    = W + F + 1;
  localparam int DNW   = DW + RW;
  localparam int GW    = W + 1 + F;
  localparam int GSW   = 2 * RW;

  logic         en;
  logic [L:1]   v_r;
  cls_t         side_r [1:S_U3];

  assign en        = !v_r[L] || res_ready;
  assign pop       = en && head_valid;
  assign res_valid = v_r[L];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[L-1:1], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= head;
      for (int i = 2; i <= S_U3; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // wind speed: squares, sum, root
  logic [RADW-1:0] a1_r, b1_r;
  logic [RADW:0]   rad_sum;
  logic [RADW-1:0] sx_r [0:SQ_N];
  logic [RADW-1:0] sr_r [0:SQ_N];
  logic            sbig_r [0:SQ_N];

  assign rad_sum = {1'b0, a1_r} + {1'b0, b1_r};

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r      <= RADW'(head.ax[W-1:0]) * RADW'(head.ax[W-1:0]);
      b1_r      <= RADW'(head.ay[W-1:0]) * RADW'(head.ay[W-1:0]);
      sx_r[0]   <= rad_sum[RADW-1:0];
      sr_r[0]   <= '0;
      sbig_r[0] <= side_r[1].big | rad_sum[RADW];
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sq
    localparam logic [RADW-1:0] BIT = RADW'(1) << (RADW - 2 - 2 * j);
    logic [RADW-1:0] t;
    assign t = sr_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sx_r[j] >= t) begin
          sx_r[j+1] <= sx_r[j] - t;
          sr_r[j+1] <= (sr_r[j] >> 1) + BIT;
        end else begin
          sx_r[j+1] <= sx_r[j];
          sr_r[j+1] <= sr_r[j] >> 1;
        end
        sbig_r[j+1] <= sbig_r[j];
      end
    end
  end

  logic [RADW-1:0] sroot;
  logic [RW-1:0]   spd_nxt;
  logic [RW-1:0]   spd_r [S_SPD:L];

  assign sroot = sr_r[SQ_N] >> 1;

  always_comb begin
    if (sbig_r[SQ_N] || (sroot > RADW'(RMASK))) begin
      spd_nxt = RMASK;
    end else if (sroot < RADW'(MIN_SPEED)) begin
      spd_nxt = MIN_SPEED;
    end else begin
      spd_nxt = sroot[RW-1:0];
    end
  end

  // coefficient products and friction velocity
  logic [2*RW-1:0] mk_r, sk_r;
  logic [UPW-1:0]  up_r;
  logic [KW-1:0]   km_r, ks_r;
  logic [USW-1:0]  ush;
  logic [RW-1:0]   ust_nxt;
  logic [RW-1:0]   ust_r [S_K:L];

  assign ush     = up_r[UPW-1:F];
  assign ust_nxt = (ush > USW'(RMASK)) ? RMASK : ush[RW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      spd_r[S_SPD] <= spd_nxt;
      for (int i = S_SPD + 1; i <= L; i++) begin
        spd_r[i] <= spd_r[i-1];
      end
      mk_r <= (2*RW)'(cfg.mc) * (2*RW)'(spd_r[S_SPD]);
      sk_r <= (2*RW)'(cfg.sc) * (2*RW)'(spd_r[S_SPD]);
      up_r <= UPW'(cfg.root) * UPW'(spd_r[S_SPD]);
      km_r <= mk_r[2*RW-1:F];
      ks_r <= sk_r[2*RW-1:F];
      ust_r[S_K] <= ust_nxt;
      for (int i = S_K + 1; i <= L; i++) begin
        ust_r[i] <= ust_r[i-1];
      end
    end
  end

  // fluxes
  logic [W-1:0] flx_out [NLANE];

  for (genvar l = 0; l < NLANE; l++) begin : g_flx
    logic [KW-1:0]  k;
    logic [W:0]     md;
    logic [KL+W:0]  pl_r;
    logic [KH+W:0]  ph_r;
    logic [PW-1:0]  p;
    logic [MW-1:0]  m;
    logic [W-1:0]   f_nxt;
    logic [W-1:0]   f_r [S_FLX:L];

    assign k  = (2'(l) == LANE_S) ? ks_r : km_r;
    assign md = side_r[S_K].md[l];
    assign p  = (PW'(ph_r) << KL) + PW'(pl_r);
    assign m  = p[PW-1:F];

    always_comb begin
      if (side_r[S_PP].dpos[l]) begin
        f_nxt = (m > MW'(SMAX)) ? SMIN : W'(0) - m[W-1:0];
      end else begin
        f_nxt = (m > MW'(SMAX)) ? SMAX : m[W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl_r <= (KL+W+1)'(k[KL-1:0]) * (KL+W+1)'(md);
        ph_r <= (KH+W+1)'(k[KW-1:KL]) * (KH+W+1)'(md);
        f_r[S_FLX] <= f_nxt;
        for (int i = S_FLX + 1; i <= L; i++) begin
          f_r[i] <= f_r[i-1];
        end
      end
    end

    assign flx_out[l] = f_r[L];
  end

  // gradients: restoring dividers by the level height
  logic [W-1:0] grd_out [NLANE];

  for (genvar l = 0; l < NLANE; l++) begin : g_grd
    logic [GW-1:0] n0;
    logic [GW-1:0] gn_r [0:RW];
    logic [RW-1:0] gq_r [0:RW];
    logic          gs_r [0:RW];
    logic [W-1:0]  g_nxt;
    logic [W-1:0]  g_r [S_GRD:L];

    assign n0 = {head.md[l], {F{1'b0}}};

    always_ff @(posedge clk) begin
      if (en) begin
        gn_r[0] <= n0;
        gq_r[0] <= '0;
        gs_r[0] <= GSW'(n0) >= (GSW'(cfg.lh) << RW);
      end
    end

    for (genvar i = 0; i < RW; i++) begin : g_step
      logic [GSW-1:0] sub;
      assign sub = GSW'(cfg.lh) << (RW - 1 - i);
      always_ff @(posedge clk) begin
        if (en) begin
          if (GSW'(gn_r[i]) >= sub) begin
            gn_r[i+1] <= gn_r[i] - sub[GW-1:0];
            gq_r[i+1] <= gq_r[i] | (RW'(1) << (RW - 1 - i));
          end else begin
            gn_r[i+1] <= gn_r[i];
            gq_r[i+1] <= gq_r[i];
          end
          gs_r[i+1] <= gs_r[i];
        end
      end
    end

    always_comb begin
      if (side_r[S_GRD-1].dneg[l]) begin
        g_nxt = gs_r[RW] ? SMIN : W'(0) - W'(gq_r[RW]);
      end else begin
        g_nxt = gs_r[RW] ? SMAX : W'(gq_r[RW]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        g_r[S_GRD] <= g_nxt;
        for (int i = S_GRD + 1; i <= L; i++) begin
          g_r[i] <= g_r[i-1];
        end
      end
    end

    assign grd_out[l] = g_r[L];
  end

  // obukhov length: cube, times five, restoring divide by buoyancy
  logic [2*RW-1:0] u2_r, u3l_r, u3h_r;
  logic [U3W-1:0]  u3_r;
  logic [NW-1:0]   n5;
  logic [DW-1:0]   dvs;
  logic [DNW-1:0]  dn_r [0:RW];
  logic [DW-1:0]   dd_r [0:RW];
  logic [RW-1:0]   dq_r [0:RW];
  logic            dsat_r [0:RW];
  logic            dbz_r [0:RW];
  logic            dbp_r [0:RW];
  logic [W-1:0]    obk_nxt;
  logic [W-1:0]    obk_r;

  assign n5  = (NW'(u3_r) << 2) + NW'(u3_r);
  assign dvs = DW'(side_r[S_U3].mb) << (F + 1);

  always_ff @(posedge clk) begin
    if (en) begin
      u2_r  <= (2*RW)'(ust_r[S_K]) * (2*RW)'(ust_r[S_K]);
      u3l_r <= (2*RW)'(u2_r[RW-1:0]) * (2*RW)'(ust_r[S_PP]);
      u3h_r <= (2*RW)'(u2_r[2*RW-1:RW]) * (2*RW)'(ust_r[S_PP]);
      u3_r  <= (U3W'(u3h_r) << RW) + U3W'(u3l_r);
      dn_r[0]   <= n5[DNW-1:0];
      dd_r[0]   <= dvs;
      dq_r[0]   <= '0;
      dsat_r[0] <= n5 >= (NW'(dvs) << RW);
      dbz_r[0]  <= side_r[S_U3].b_zero;
      dbp_r[0]  <= side_r[S_U3].b_pos;
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_div
    logic [DNW-1:0] sub;
    assign sub = DNW'(dd_r[i]) << (RW - 1 - i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (dn_r[i] >= sub) begin
          dn_r[i+1] <= dn_r[i] - sub;
          dq_r[i+1] <= dq_r[i] | (RW'(1) << (RW - 1 - i));
        end else begin
          dn_r[i+1] <= dn_r[i];
          dq_r[i+1] <= dq_r[i];
        end
        dd_r[i+1]   <= dd_r[i];
        dsat_r[i+1] <= dsat_r[i];
        dbz_r[i+1]  <= dbz_r[i];
        dbp_r[i+1]  <= dbp_r[i];
      end
    end
  end

  always_comb begin
    if (dbz_r[RW]) begin
      obk_nxt = SMIN;
    end else if (dbp_r[RW]) begin
      obk_nxt = dsat_r[RW] ? SMIN : W'(0) - W'(dq_r[RW]);
    end else begin
      obk_nxt = dsat_r[RW] ? SMAX : W'(dq_r[RW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      obk_r <= obk_nxt;
    end
  end

  assign res.wind_diff    = spd_r[L];
  assign res.u_flux       = flx_out[LANE_U];
  assign res.v_flux       = flx_out[LANE_V];
  assign res.s_flux       = flx_out[LANE_S];
  assign res.u_grad       = grd_out[LANE_U];
  assign res.v_grad       = grd_out[LANE_V];
  assign res.s_grad       = grd_out[LANE_S];
  assign res.friction_vel = ust_r[L];
  assign res.obukhov_len  = obk_r;

endmodule

/* dv/tb_bulk_surface_flux_core.sv */
// tb_bulk_surface_flux_core: self-checking bench for the bulk surface flux core,
// directed table then random cells scored against a behavioural predictor
// depends on bsf_pkg, bsf_if and the core rtl
`timescale 1ns / 100ps

module tb_bulk_surface_flux_core;
  import bsf_pkg::*;

  typedef struct {
    logic [W-1:0] f [11];
  } cell_t;

  typedef struct {
    logic [RW-1:0] wind_diff;
    logic [W-1:0]  u_flux, v_flux, u_grad, v_grad, s_flux, s_grad;
    logic [RW-1:0] friction_vel;
    logic [W-1:0]  obukhov_len;
  } flux_t;

  typedef struct {
    cell_t stim;
    bit    fixed;
    flux_t res;
  } row_t;

  localparam int LIMIT = 20000;
  localparam int FB    = 16;
  localparam logic [63:0] WM  = 64'hFFFF_FFFF;
  localparam logic [63:0] SMX = 64'h7FFF_FFFF;

  logic clk, rst_n;
  bsf_in_if  in_ch ();
  bsf_out_if out_ch ();
  bsf_cfg_if cfg_ch ();

  bulk_surface_flux_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  logic [63:0] mom_coef, sca_coef, lvl_height;
  flux_t expected_q [$];
  int errors;
  int idle_cycles;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat(bit neg, logic [63:0] m);
    if (neg) return (m > SMX) ? (SMX + 1) : ((64'd0 - m) & WM);
    return (m > SMX) ? SMX : m;
  endfunction

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic logic [63:0] flux_calc(logic [63:0] coef, logic [63:0] spd, longint d);
    logic [63:0] k;
    logic [127:0] p;
    k = (coef * spd) >> FB;
    p = 128'(k) * 128'(mag(d));
    if ((p >> (64 + FB)) != 0) return sat(d > 0, '1);
    return sat(d > 0, 64'(p >> FB));
  endfunction

  function automatic logic [63:0] grad_calc(longint d);
    logic [63:0] h;
    h = (lvl_height != 0) ? lvl_height : 64'd1;
    return sat(d < 0, (mag(d) << FB) / h);
  endfunction

  function automatic logic [63:0] obukhov_calc(logic [63:0] us, longint b);
    logic [191:0] num;
    logic [127:0] q;
    logic [63:0] dv;
    if (b == 0) return SMX + 1;
    num = 192'(us) * 192'(us) * 192'(us) * 192'd5;
    dv = mag(b) << (FB + 1);
    if ((num >> 64) >= 192'(dv)) return sat(b > 0, '1);
    q = 128'(num / 192'(dv));
    return sat(b > 0, 64'(q));
  endfunction

  function automatic flux_t predict_fluxes(cell_t c);
    longint v [11];
    longint du, dv, ds, dx, dy;
    logic [63:0] ax, ay, a, b, spd, rt, us;
    flux_t r;
    for (int i = 0; i < 11; i++) v[i] = longint'($signed(c.f[i]));
    du = v[0] - v[4];
    dv = v[2] - v[6];
    ds = v[8] - v[9];
    dx = (v[0] + v[1]) - (v[4] + v[5]);
    dy = (v[2] + v[3]) - (v[6] + v[7]);
    ax = mag(dx);
    ay = mag(dy);
    if (ax >= 64'h1_0000_0000 || ay >= 64'h1_0000_0000) begin
      spd = SMX;
    end else begin
      a = ax * ax;
      b = ay * ay;
      if (a > ~b) spd = SMX;
      else begin
        spd = isqrt(a + b) >> 1;
        if (spd > SMX) spd = SMX;
        if (spd < 64'd6554) spd = 64'd6554;
      end
    end
    rt = isqrt(mom_coef << FB);
    us = (rt * spd) >> FB;
    if (us > SMX) us = SMX;
    r.wind_diff    = RW'(spd);
    r.u_flux       = W'(flux_calc(mom_coef, spd, du));
    r.v_flux       = W'(flux_calc(mom_coef, spd, dv));
    r.u_grad       = W'(grad_calc(du));
    r.v_grad       = W'(grad_calc(dv));
    r.s_flux       = W'(flux_calc(sca_coef, spd, ds));
    r.s_grad       = W'(grad_calc(ds));
    r.friction_vel = RW'(us);
    r.obukhov_len  = W'(obukhov_calc(us, v[10]));
    return r;
  endfunction

  task automatic write_reg(logic [CIW-1:0] idx, logic [W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_MOMENTUM_COEF) mom_coef = val & SMX;
    else if (idx == REG_SCALAR_COEF) sca_coef = val & SMX;
    else if (idx == REG_LEVEL_HEIGHT) lvl_height = val & SMX;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    repeat (30) @(posedge clk);
  endtask

  task automatic drain;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic send_cell(cell_t c);
    in_ch.valid        <= 1'b1;
    in_ch.u_here       <= c.f[0];
    in_ch.u_east       <= c.f[1];
    in_ch.v_here       <= c.f[2];
    in_ch.v_north      <= c.f[3];
    in_ch.u_surf_here  <= c.f[4];
    in_ch.u_surf_east  <= c.f[5];
    in_ch.v_surf_here  <= c.f[6];
    in_ch.v_surf_north <= c.f[7];
    in_ch.scalar_air   <= c.f[8];
    in_ch.scalar_surf  <= c.f[9];
    in_ch.buoy_flux    <= c.f[10];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_row(row_t r);
    send_cell(r.stim);
    expected_q.push_back(r.fixed ? r.res : predict_fluxes(r.stim));
  endtask

  function automatic logic [W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return W'($urandom_range(0, 8)) << $urandom_range(0, 31);
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return W'($signed(W'($urandom_range(0, 131071)) - 32'd65536)) <<< $urandom_range(0, 8);
      default: return $urandom();
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    for (int i = 0; i < 11; i++) c.f[i] = rand_word();
    if ($urandom_range(0, 9) == 0) c.f[10] = '0;
    return c;
  endfunction

  task automatic random_run(int n);
    int gap;
    @(negedge clk);
    for (int i = 0; i < n; i++) begin
      send_row('{stim: rand_cell(), fixed: 0, res: '{default: '0}});
      if ($urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else case (($time / 20) % 97 > 60 ? 2 : $urandom_range(0, 3))
      0:       out_ch.ready <= 1'b0;
      default: out_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    flux_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word wind_diff=%h", $time, out_ch.wind_diff);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.wind_diff !== out_ch.wind_diff || exp_r.u_flux !== out_ch.u_flux ||
            exp_r.v_flux !== out_ch.v_flux || exp_r.u_grad !== out_ch.u_grad ||
            exp_r.v_grad !== out_ch.v_grad || exp_r.s_flux !== out_ch.s_flux ||
            exp_r.s_grad !== out_ch.s_grad || exp_r.friction_vel !== out_ch.friction_vel ||
            exp_r.obukhov_len !== out_ch.obukhov_len) begin
          $display("%0t: expected %h %h %h %h %h %h %h %h %h", $time, exp_r.wind_diff,
                   exp_r.u_flux, exp_r.v_flux, exp_r.u_grad, exp_r.v_grad, exp_r.s_flux,
                   exp_r.s_grad, exp_r.friction_vel, exp_r.obukhov_len);
          $display("%0t: actual   %h %h %h %h %h %h %h %h %h", $time, out_ch.wind_diff,
                   out_ch.u_flux, out_ch.v_flux, out_ch.u_grad, out_ch.v_grad, out_ch.s_flux,
                   out_ch.s_grad, out_ch.friction_vel, out_ch.obukhov_len);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LIMIT) begin
      $display("bulk_surface_flux_core: mismatch");
      $finish;
    end
  end

  initial begin
    row_t table_rows [$];
    cell_t c;
    flux_t fz;
    errors = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    {in_ch.u_here, in_ch.u_east, in_ch.v_here, in_ch.v_north} = '0;
    {in_ch.u_surf_here, in_ch.u_surf_east, in_ch.v_surf_here, in_ch.v_surf_north} = '0;
    {in_ch.scalar_air, in_ch.scalar_surf, in_ch.buoy_flux} = '0;
    mom_coef = 66;
    sca_coef = 66;
    lvl_height = 65536;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (40) @(posedge clk);

    // all-zero cell after reset: floor speed, zero buoyancy flux
    fz = '{wind_diff: 31'd6554, friction_vel: 31'd6554 * 31'd2079 >> 16,
           obukhov_len: 32'h8000_0000, default: '0};
    for (int i = 0; i < 11; i++) c.f[i] = '0;
    table_rows.push_back('{stim: c, fixed: 1, res: fz});
    for (int k = 0; k < 11; k++) begin
      for (int i = 0; i < 11; i++) c.f[i] = '0;
      c.f[k] = 32'h7FFF_FFFF;
      table_rows.push_back('{stim: c, fixed: 0, res: fz});
      c.f[k] = 32'h8000_0000;
      table_rows.push_back('{stim: c, fixed: 0, res: fz});
    end
    for (int i = 0; i < 11; i++) c.f[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    table_rows.push_back('{stim: c, fixed: 0, res: fz});
    for (int i = 0; i < 11; i++) c.f[i] = 32'hFFFF_FFFF;
    table_rows.push_back('{stim: c, fixed: 0, res: fz});
    @(negedge clk);
    foreach (table_rows[i]) send_row(table_rows[i]);
    in_ch.valid <= 1'b0;
    drain();

    random_run(300);
    drain();
    write_reg(REG_MOMENTUM_COEF, 32'h7FFF_FFFF);
    write_reg(REG_SCALAR_COEF, 32'h0);
    write_reg(REG_LEVEL_HEIGHT, 32'h0);
    write_reg(CIW'(3), $urandom());
    random_run(300);
    drain();
    write_reg(REG_MOMENTUM_COEF, 32'h0);
    write_reg(REG_SCALAR_COEF, 32'h7FFF_FFFF);
    write_reg(REG_LEVEL_HEIGHT, 32'hFFFF_FFFF);
    random_run(300);
    drain();
    for (int p = 0; p < 2; p++) begin
      write_reg(REG_MOMENTUM_COEF, $urandom_range(0, 65536 * 4));
      write_reg(REG_SCALAR_COEF, $urandom());
      write_reg(REG_LEVEL_HEIGHT, $urandom_range(1, 65536 * 64));
      random_run(300);
      drain();
    end

    if (errors == 0) begin
      $display("bulk_surface_flux_core: match");
    end else begin
      $display("bulk_surface_flux_core: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bsf_pkg.sv
hw/rtl/bsf_if.sv
hw/rtl/bsf_cfg.sv
hw/rtl/bsf_front.sv
hw/rtl/bsf_queue.sv
hw/rtl/bsf_back.sv
hw/rtl/bulk_surface_flux_core.sv
dv/tb_bulk_surface_flux_core.sv
